[src/tml_pkg.sv]
// ----------------------------------------------------------------------------
// tml_pkg
// Shared types, token kinds, character codes and helpers for the TOML lexer.
// ----------------------------------------------------------------------------
package tml_pkg;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_LBR,
    MODE_RBR,
    MODE_STR,
    MODE_ESC,
    MODE_HEX
  } mode_t;

  localparam logic [3:0] KIND_EOF       = 4'd0;
  localparam logic [3:0] KIND_NEWLINE   = 4'd1;
  localparam logic [3:0] KIND_EQUALS    = 4'd2;
  localparam logic [3:0] KIND_DOT       = 4'd3;
  localparam logic [3:0] KIND_COMMA     = 4'd4;
  localparam logic [3:0] KIND_LBRACE    = 4'd5;
  localparam logic [3:0] KIND_RBRACE    = 4'd6;
  localparam logic [3:0] KIND_LBRACKET  = 4'd7;
  localparam logic [3:0] KIND_DLBRACKET = 4'd8;
  localparam logic [3:0] KIND_RBRACKET  = 4'd9;
  localparam logic [3:0] KIND_DRBRACKET = 4'd10;
  localparam logic [3:0] KIND_STRING    = 4'd11;
  localparam logic [3:0] KIND_INVALID   = 4'd12;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_EQUALS = 8'h3D;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UF     = 8'h46;
  localparam logic [7:0] CH_UU     = 8'h55;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LB     = 8'h62;
  localparam logic [7:0] CH_LE     = 8'h65;
  localparam logic [7:0] CH_LF_F   = 8'h66;
  localparam logic [7:0] CH_LN     = 8'h6E;
  localparam logic [7:0] CH_LR     = 8'h72;
  localparam logic [7:0] CH_LT     = 8'h74;
  localparam logic [7:0] CH_LU     = 8'h75;
  localparam logic [7:0] CH_LX     = 8'h78;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  localparam logic [3:0] HEX_DIGITS_X  = 4'd2;
  localparam logic [3:0] HEX_DIGITS_LU = 4'd4;
  localparam logic [3:0] HEX_DIGITS_UU = 4'd8;

  localparam logic [31:0] CP_SURR_LO = 32'h0000_D800;
  localparam logic [31:0] CP_SURR_HI = 32'h0000_DFFF;
  localparam logic [31:0] CP_MAX     = 32'h0010_FFFF;

  // bit 4 set marks a byte that is no hex digit
  function automatic logic [4:0] hex_val(input logic [7:0] b);
    logic [4:0] v;
    v = 5'h10;
    if (b >= CH_0 && b <= CH_9) begin
      v = {1'b0, b[3:0]};
    end else if ((b >= CH_LA && b <= CH_LF_F) || (b >= CH_UA && b <= CH_UF)) begin
      v = {1'b0, b[3:0] + 4'd9};
    end
    return v;
  endfunction

endpackage

[src/tml_core.sv]
// ----------------------------------------------------------------------------
// tml_core
// Scanner state and single-pass step logic; yields up to two tokens per byte.
// ----------------------------------------------------------------------------
module tml_core #(
  parameter int OFFSET_BITS = 24,
  parameter int LINE_BITS   = 20,
  parameter int COLUMN_BITS = 16,
  parameter int TOK_W       = 4 + 2 * OFFSET_BITS + LINE_BITS + COLUMN_BITS + 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             fire,
  input  logic [7:0]       byte_in,
  input  logic             end_in,
  output logic [1:0]       tok_cnt,
  output logic [TOK_W-1:0] tok0,
  output logic [TOK_W-1:0] tok1
);

  typedef struct packed {
    logic [3:0]             kind;
    logic [OFFSET_BITS-1:0] start;
    logic [OFFSET_BITS-1:0] len;
    logic [LINE_BITS-1:0]   line;
    logic [COLUMN_BITS-1:0] col;
    logic                   last;
  } tok_t;

  tml_pkg::mode_t         mode, mode_next;
  logic [3:0]             hex_left, hex_left_next;
  logic [31:0]            acc, acc_next;
  logic [OFFSET_BITS-1:0] tsp, tsp_next;
  logic [OFFSET_BITS-1:0] pos, pos_next;
  logic [LINE_BITS-1:0]   line, line_next;
  logic [COLUMN_BITS-1:0] col, col_next;
  logic                   fin, fin_next;

  logic [OFFSET_BITS-1:0] pos_c;
  logic [LINE_BITS-1:0]   line_c;
  logic [COLUMN_BITS-1:0] col_c;
  logic                   is_end;
  logic [4:0]             hv;
  logic [31:0]            acc_sh;
  logic [3:0]             hex_dec;

  tok_t       toks [2];
  logic [1:0] cnt;

  function automatic tok_t mk(input logic [3:0] kind, input logic [OFFSET_BITS-1:0] start,
                              input logic [OFFSET_BITS-1:0] p, input logic [LINE_BITS-1:0] l,
                              input logic [COLUMN_BITS-1:0] c);
    tok_t t;
    t.kind  = kind;
    t.start = start;
    t.len   = p - start;
    t.line  = l;
    t.col   = c;
    t.last  = 1'b0;
    return t;
  endfunction

  // position after taking this byte, saturating
  always_comb begin
    is_end  = end_in || (byte_in == tml_pkg::CH_NUL);
    pos_c   = (pos == '1) ? pos : pos + 1'b1;
    if (byte_in == tml_pkg::CH_LF) begin
      line_c = (line == '1) ? line : line + 1'b1;
      col_c  = COLUMN_BITS'(1);
    end else begin
      line_c = line;
      col_c  = (col == '1) ? col : col + 1'b1;
    end
    hv      = tml_pkg::hex_val(byte_in);
    acc_sh  = {acc[27:0], hv[3:0]};
    hex_dec = (hex_left == 4'd0) ? 4'd0 : hex_left - 4'd1;
  end

  always_comb begin
    logic       fresh;
    logic       fk_emit;
    logic [7:0] want;
    logic [3:0] single;
    logic [3:0] fkind;
    mode_next     = mode;
    hex_left_next = hex_left;
    acc_next      = acc;
    tsp_next      = tsp;
    pos_next      = pos;
    line_next     = line;
    col_next      = col;
    fin_next      = fin;
    toks[0]       = '0;
    toks[1]       = '0;
    cnt           = 2'd0;
    fresh         = 1'b0;
    fk_emit       = 1'b0;
    fkind         = tml_pkg::KIND_INVALID;
    want          = (mode == tml_pkg::MODE_LBR) ? tml_pkg::CH_LBRACK : tml_pkg::CH_RBRACK;
    single        = (mode == tml_pkg::MODE_LBR) ? tml_pkg::KIND_LBRACKET
                                                : tml_pkg::KIND_RBRACKET;
    if (!fin) begin
      case (mode)
        tml_pkg::MODE_LBR, tml_pkg::MODE_RBR: begin
          mode_next = tml_pkg::MODE_IDLE;
          if (!is_end && byte_in == want) begin
            pos_next = pos_c; line_next = line_c; col_next = col_c;
            toks[cnt[0]] = mk(single + 4'd1, tsp, pos_next, line_next, col_next);
            cnt = cnt + 2'd1;
          end else begin
            toks[cnt[0]] = mk(single, tsp, pos_next, line_next, col_next);
            cnt = cnt + 2'd1;
            fresh = 1'b1;
          end
        end
        tml_pkg::MODE_STR: begin
          if (is_end || byte_in == tml_pkg::CH_LF || byte_in == tml_pkg::CH_CR) begin
            toks[cnt[0]] = mk(tml_pkg::KIND_INVALID, tsp, pos_next, line_next, col_next);
            cnt = cnt + 2'd1;
            fresh = 1'b1;
          end else if (byte_in == tml_pkg::CH_BSLASH) begin
            pos_next = pos_c; line_next = line_c; col_next = col_c;
            mode_next = tml_pkg::MODE_ESC;
          end else if (byte_in == tml_pkg::CH_QUOTE) begin
            toks[cnt[0]] = mk(tml_pkg::KIND_STRING, tsp, pos_next, line_next, col_next);
            cnt = cnt + 2'd1;
            pos_next = pos_c; line_next = line_c; col_next = col_c;
            mode_next = tml_pkg::MODE_IDLE;
          end else begin
            pos_next = pos_c; line_next = line_c; col_next = col_c;
          end
        end
        tml_pkg::MODE_ESC: begin
          if (!is_end && (byte_in inside {tml_pkg::CH_LB, tml_pkg::CH_LT, tml_pkg::CH_LN,
                                          tml_pkg::CH_LF_F, tml_pkg::CH_LR, tml_pkg::CH_QUOTE,
                                          tml_pkg::CH_BSLASH, tml_pkg::CH_LE})) begin
            pos_next = pos_c; line_next = line_c; col_next = col_c;
            mode_next = tml_pkg::MODE_STR;
          end else if (!is_end && (byte_in inside {tml_pkg::CH_LX, tml_pkg::CH_LU,
                                                   tml_pkg::CH_UU})) begin
            pos_next = pos_c; line_next = line_c; col_next = col_c;
            if (byte_in == tml_pkg::CH_LX) begin
              hex_left_next = tml_pkg::HEX_DIGITS_X;
            end else if (byte_in == tml_pkg::CH_LU) begin
              hex_left_next = tml_pkg::HEX_DIGITS_LU;
            end else begin
              hex_left_next = tml_pkg::HEX_DIGITS_UU;
            end
            acc_next  = '0;
            mode_next = tml_pkg::MODE_HEX;
          end else begin
            toks[cnt[0]] = mk(tml_pkg::KIND_INVALID, tsp, pos_next, line_next, col_next);
            cnt = cnt + 2'd1;
            fresh = 1'b1;
          end
        end
        tml_pkg::MODE_HEX: begin
          if (is_end || hv[4]) begin
            toks[cnt[0]] = mk(tml_pkg::KIND_INVALID, tsp, pos_next, line_next, col_next);
            cnt = cnt + 2'd1;
            fresh = 1'b1;
          end else begin
            acc_next = acc_sh;
            pos_next = pos_c; line_next = line_c; col_next = col_c;
            hex_left_next = hex_dec;
            if (hex_dec == 4'd0) begin
              if ((acc_sh >= tml_pkg::CP_SURR_LO && acc_sh <= tml_pkg::CP_SURR_HI) ||
                  acc_sh > tml_pkg::CP_MAX) begin
                toks[cnt[0]] = mk(tml_pkg::KIND_INVALID, tsp, pos_next, line_next, col_next);
                cnt = cnt + 2'd1;
                mode_next = tml_pkg::MODE_IDLE;
              end else begin
                mode_next = tml_pkg::MODE_STR;
              end
            end
          end
        end
        default: begin
          fresh = 1'b1;
        end
      endcase

      // byte starts a new token
      if (fresh) begin
        mode_next = tml_pkg::MODE_IDLE;
        if (is_end) begin
          toks[cnt[0]] = mk(tml_pkg::KIND_EOF, pos, pos, line, col);
          cnt = cnt + 2'd1;
          fin_next = 1'b1;
        end else begin
          case (byte_in)
            tml_pkg::CH_SPACE, tml_pkg::CH_TAB: begin
              pos_next = pos_c; line_next = line_c; col_next = col_c;
            end
            tml_pkg::CH_LBRACK: begin
              tsp_next = pos;
              pos_next = pos_c; line_next = line_c; col_next = col_c;
              mode_next = tml_pkg::MODE_LBR;
            end
            tml_pkg::CH_RBRACK: begin
              tsp_next = pos;
              pos_next = pos_c; line_next = line_c; col_next = col_c;
              mode_next = tml_pkg::MODE_RBR;
            end
            tml_pkg::CH_QUOTE: begin
              pos_next = pos_c; line_next = line_c; col_next = col_c;
              tsp_next = pos_c;
              mode_next = tml_pkg::MODE_STR;
            end
            tml_pkg::CH_LF:     begin fk_emit = 1'b1; fkind = tml_pkg::KIND_NEWLINE; end
            tml_pkg::CH_EQUALS: begin fk_emit = 1'b1; fkind = tml_pkg::KIND_EQUALS; end
            tml_pkg::CH_DOT:    begin fk_emit = 1'b1; fkind = tml_pkg::KIND_DOT; end
            tml_pkg::CH_COMMA:  begin fk_emit = 1'b1; fkind = tml_pkg::KIND_COMMA; end
            tml_pkg::CH_LBRACE: begin fk_emit = 1'b1; fkind = tml_pkg::KIND_LBRACE; end
            tml_pkg::CH_RBRACE: begin fk_emit = 1'b1; fkind = tml_pkg::KIND_RBRACE; end
            default:            begin fk_emit = 1'b1; fkind = tml_pkg::KIND_INVALID; end
          endcase
          if (fk_emit) begin
            pos_next = pos_c; line_next = line_c; col_next = col_c;
            toks[cnt[0]] = mk(fkind, pos, pos_next, line_next, col_next);
            cnt = cnt + 2'd1;
          end
        end
      end
    end

    if (cnt == 2'd1) begin
      toks[0].last = 1'b1;
    end else if (cnt == 2'd2) begin
      toks[1].last = 1'b1;
    end
  end

  assign tok_cnt = cnt;
  assign tok0    = toks[0];
  assign tok1    = toks[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= tml_pkg::MODE_IDLE;
      hex_left <= 4'd0;
      acc      <= '0;
      tsp      <= '0;
      pos      <= '0;
      line     <= LINE_BITS'(1);
      col      <= COLUMN_BITS'(1);
      fin      <= 1'b0;
    end else if (fire) begin
      mode     <= mode_next;
      hex_left <= hex_left_next;
      acc      <= acc_next;
      tsp      <= tsp_next;
      pos      <= pos_next;
      line     <= line_next;
      col      <= col_next;
      fin      <= fin_next;
    end
  end

endmodule

[src/tml_obuf.sv]
// ----------------------------------------------------------------------------
// tml_obuf
// Two-entry result buffer; loads a whole run of tokens, drains one per cycle while not stalled.
// ----------------------------------------------------------------------------
module tml_obuf #(
  parameter int TOK_W = 89
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  logic [1:0]       load_cnt,
  input  logic [TOK_W-1:0] d0,
  input  logic [TOK_W-1:0] d1,
  output logic             can_load,
  output logic             valid,
  input  logic             stall,
  output logic [TOK_W-1:0] q
);

  logic [TOK_W-1:0] slot0, slot1;
  logic [1:0]       count;
  logic             pop;

  assign valid    = (count != 2'd0);
  assign pop      = valid && !stall;
  assign can_load = (count == 2'd0) || (count == 2'd1 && !stall);
  assign q        = slot0;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (load) begin
      count <= load_cnt;
    end else if (pop) begin
      count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slot0 <= d0;
      slot1 <= d1;
    end else if (pop) begin
      slot0 <= slot1;
    end
  end

endmodule

[src/toml_basic_token_lexer.sv]
// ----------------------------------------------------------------------------
// toml_basic_token_lexer
// Streaming lexer for the basic TOML token set, one text byte per word.
// ----------------------------------------------------------------------------
// input channel: in_valid / in_stall carry data_byte and end_of_input; a zero
//   byte or end_of_input set closes the text with an eof token, after which
//   further words are taken and dropped until reset
// output channel: out_valid / out_stall carry one token per word; last_of_run
//   marks the final token caused by one input byte (a byte gives 0 to 2)
// path: a taken byte waits in the input register, its tokens in the result buffer
// throughput: one byte per cycle while out_stall is low and each byte gives at
//   most one token; a byte giving two tokens holds the input until a token
//   drains, since the two-entry result buffer drains a single token per cycle
// stall: a stalled token holds steady; the input register then fills and
//   in_stall rises until the buffer can take the next run
// reset: synchronous, clears the scanner to idle at line 1, column 1,
//   offset 0 and empties the input register and result buffer
// ----------------------------------------------------------------------------
module toml_basic_token_lexer #(
  parameter int OFFSET_BITS = 24,
  parameter int LINE_BITS   = 20,
  parameter int COLUMN_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             data_byte,
  input  logic                   end_of_input,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [3:0]             token_kind,
  output logic [OFFSET_BITS-1:0] start_offset,
  output logic [OFFSET_BITS-1:0] token_length,
  output logic [LINE_BITS-1:0]   line_number,
  output logic [COLUMN_BITS-1:0] column_number,
  output logic                   last_of_run
);

  localparam int TOK_W = 4 + 2 * OFFSET_BITS + LINE_BITS + COLUMN_BITS + 1;

  logic             in_full;
  logic [7:0]       in_byte;
  logic             in_end;
  logic             fire;
  logic             can_load;
  logic             in_take;
  logic [1:0]       tok_cnt;
  logic [TOK_W-1:0] tok0, tok1, head;

  assign fire     = in_full && can_load;
  assign in_stall = in_full && !can_load;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_take) begin
      in_full <= 1'b1;
    end else if (fire) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_byte <= data_byte;
      in_end  <= end_of_input;
    end
  end

  tml_core #(
    .OFFSET_BITS (OFFSET_BITS),
    .LINE_BITS   (LINE_BITS),
    .COLUMN_BITS (COLUMN_BITS),
    .TOK_W       (TOK_W)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .fire    (fire),
    .byte_in (in_byte),
    .end_in  (in_end),
    .tok_cnt (tok_cnt),
    .tok0    (tok0),
    .tok1    (tok1)
  );

  tml_obuf #(
    .TOK_W (TOK_W)
  ) u_obuf (
    .clk      (clk),
    .rst      (rst),
    .load     (fire),
    .load_cnt (tok_cnt),
    .d0       (tok0),
    .d1       (tok1),
    .can_load (can_load),
    .valid    (out_valid),
    .stall    (out_stall),
    .q        (head)
  );

  assign {token_kind, start_offset, token_length, line_number, column_number, last_of_run} = head;

endmodule

[src/tml_checker.sv]
// ----------------------------------------------------------------------------
// tml_checker
// Port-level checks on the token output of the lexer, bound to the top level.
// ----------------------------------------------------------------------------
module tml_checker #(
  parameter int OFFSET_BITS = 24,
  parameter int LINE_BITS   = 20,
  parameter int COLUMN_BITS = 16
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   out_valid,
  input logic                   out_stall,
  input logic [3:0]             token_kind,
  input logic [OFFSET_BITS-1:0] token_length,
  input logic [LINE_BITS-1:0]   line_number,
  input logic [COLUMN_BITS-1:0] column_number,
  input logic                   last_of_run
);

  // stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(token_kind) && $stable(token_length)
      && $stable(last_of_run))
    else $error("stalled output word changed");

  a_eof_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && token_kind == tml_pkg::KIND_EOF |-> token_length == '0 && last_of_run)
    else $error("eof token not empty or not last of run");

  a_line_col: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> line_number != '0 && column_number != '0)
    else $error("line or column is zero");

  // the first token of a run of two is always a single bracket or an invalid token
  a_pair_first: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_of_run |-> token_kind == tml_pkg::KIND_LBRACKET
      || token_kind == tml_pkg::KIND_RBRACKET || token_kind == tml_pkg::KIND_INVALID)
    else $error("unexpected first token of a pair");

endmodule

bind toml_basic_token_lexer tml_checker #(
  .OFFSET_BITS (OFFSET_BITS),
  .LINE_BITS   (LINE_BITS),
  .COLUMN_BITS (COLUMN_BITS)
) u_tml_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .token_kind    (token_kind),
  .token_length  (token_length),
  .line_number   (line_number),
  .column_number (column_number),
  .last_of_run   (last_of_run)
);

[verif/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the TOML token lexer. A queued byte stream of
// directed text, random well-formed and broken fragments and one long
// string is driven with random gaps; every token is predicted by a local
// scanner and checked field by field against the block's output words.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int OB = 24;
  localparam int LB = 20;
  localparam int CB = 16;

  localparam logic [OB-1:0] OFS_MAX  = '1;
  localparam logic [LB-1:0] LINE_MAX = '1;
  localparam logic [CB-1:0] COL_MAX  = '1;

  typedef struct packed {
    logic [3:0]    kind;
    logic [OB-1:0] start;
    logic [OB-1:0] len;
    logic [LB-1:0] line;
    logic [CB-1:0] col;
    logic          last;
  } token_t;

  typedef struct {
    logic [7:0] ch;
    logic       eoi;
    bit         drain;
  } text_word_t;

  logic          clk          = 1'b0;
  logic          rst          = 1'b1;
  logic          in_valid     = 1'b0;
  logic          in_stall;
  logic [7:0]    data_byte    = 8'h00;
  logic          end_of_input = 1'b0;
  logic          out_valid;
  logic          out_stall    = 1'b0;
  logic [3:0]    token_kind;
  logic [OB-1:0] start_offset;
  logic [OB-1:0] token_length;
  logic [LB-1:0] line_number;
  logic [CB-1:0] column_number;
  logic          last_of_run;

  toml_basic_token_lexer #(
    .OFFSET_BITS (OB),
    .LINE_BITS   (LB),
    .COLUMN_BITS (CB)
  ) u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .data_byte     (data_byte),
    .end_of_input  (end_of_input),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .token_kind    (token_kind),
    .start_offset  (start_offset),
    .token_length  (token_length),
    .line_number   (line_number),
    .column_number (column_number),
    .last_of_run   (last_of_run)
  );

  always #6 clk = ~clk;

  // scanner state
  tml_pkg::mode_t lex_mode   = tml_pkg::MODE_IDLE;
  logic [3:0]     hex_left   = '0;
  logic [31:0]    code_point = '0;
  logic [OB-1:0]  str_start  = '0;
  logic [OB-1:0]  byte_pos   = '0;
  logic [LB-1:0]  cur_line   = LB'(1);
  logic [CB-1:0]  cur_col    = CB'(1);
  bit             lex_done   = 1'b0;

  token_t     step_tokens[$];
  token_t     due_tokens[$];
  text_word_t text_words[$];

  int   sent_cnt    = 0;
  int   taken_cnt   = 0;
  int   tokens_seen = 0;
  int   mismatches  = 0;
  int   hold_left   = 0;
  bit   hold_done   = 1'b0;
  bit   kinds_seen[16];
  int   longest_str = 0;
  int   col_peak    = 0;
  logic quiet;

  logic [7:0] esc_letters[8] = '{tml_pkg::CH_LB, tml_pkg::CH_LT, tml_pkg::CH_LN,
                                 tml_pkg::CH_LF_F, tml_pkg::CH_LR, tml_pkg::CH_QUOTE,
                                 tml_pkg::CH_BSLASH, tml_pkg::CH_LE};
  logic [7:0] hex_letters[3] = '{tml_pkg::CH_LX, tml_pkg::CH_LU, tml_pkg::CH_UU};
  logic [7:0] punct_bytes[8] = '{tml_pkg::CH_LF, tml_pkg::CH_EQUALS, tml_pkg::CH_DOT,
                                 tml_pkg::CH_COMMA, tml_pkg::CH_LBRACE,
                                 tml_pkg::CH_RBRACE, tml_pkg::CH_LBRACK,
                                 tml_pkg::CH_RBRACK};

  assign quiet = (taken_cnt >= 500) && (taken_cnt < 900);

  function automatic void advance(input logic [7:0] b);
    if (b == tml_pkg::CH_LF) begin
      if (cur_line != LINE_MAX) cur_line++;
      cur_col = CB'(1);
    end else if (cur_col != COL_MAX) begin
      cur_col++;
    end
    if (byte_pos != OFS_MAX) byte_pos++;
  endfunction

  function automatic void add_token(input logic [3:0] kind, input logic [OB-1:0] start);
    token_t t;
    t.kind  = kind;
    t.start = start;
    t.len   = byte_pos - start;
    t.line  = cur_line;
    t.col   = cur_col;
    t.last  = 1'b0;
    step_tokens.push_back(t);
  endfunction

  function automatic void lex_fresh(input logic [7:0] b, input bit eoi);
    logic [OB-1:0] s;
    logic [3:0]    kind;
    s = byte_pos;
    lex_mode = tml_pkg::MODE_IDLE;
    if (eoi) begin
      add_token(tml_pkg::KIND_EOF, s);
      lex_done = 1'b1;
      return;
    end
    kind = tml_pkg::KIND_INVALID;
    case (b)
      tml_pkg::CH_SPACE, tml_pkg::CH_TAB: begin
        advance(b);
        return;
      end
      tml_pkg::CH_LBRACK, tml_pkg::CH_RBRACK: begin
        str_start = s;
        advance(b);
        lex_mode = (b == tml_pkg::CH_LBRACK) ? tml_pkg::MODE_LBR : tml_pkg::MODE_RBR;
        return;
      end
      tml_pkg::CH_QUOTE: begin
        advance(b);
        str_start = byte_pos;
        lex_mode = tml_pkg::MODE_STR;
        return;
      end
      tml_pkg::CH_LF:     kind = tml_pkg::KIND_NEWLINE;
      tml_pkg::CH_EQUALS: kind = tml_pkg::KIND_EQUALS;
      tml_pkg::CH_DOT:    kind = tml_pkg::KIND_DOT;
      tml_pkg::CH_COMMA:  kind = tml_pkg::KIND_COMMA;
      tml_pkg::CH_LBRACE: kind = tml_pkg::KIND_LBRACE;
      tml_pkg::CH_RBRACE: kind = tml_pkg::KIND_RBRACE;
      default:            kind = tml_pkg::KIND_INVALID;
    endcase
    advance(b);
    add_token(kind, s);
  endfunction

  function automatic void lex_byte(input logic [7:0] b, input logic eoi_in);
    bit         eoi;
    logic [4:0] digit;
    token_t     t;
    eoi = eoi_in || (b == tml_pkg::CH_NUL);
    if (lex_done) return;
    case (lex_mode)
      tml_pkg::MODE_LBR, tml_pkg::MODE_RBR: begin
        if (!eoi && b == ((lex_mode == tml_pkg::MODE_LBR) ? tml_pkg::CH_LBRACK
                                                           : tml_pkg::CH_RBRACK)) begin
          advance(b);
          add_token((lex_mode == tml_pkg::MODE_LBR) ? tml_pkg::KIND_DLBRACKET
                                                    : tml_pkg::KIND_DRBRACKET, str_start);
          lex_mode = tml_pkg::MODE_IDLE;
        end else begin
          add_token((lex_mode == tml_pkg::MODE_LBR) ? tml_pkg::KIND_LBRACKET
                                                    : tml_pkg::KIND_RBRACKET, str_start);
          lex_fresh(b, eoi);
        end
      end
      tml_pkg::MODE_STR: begin
        if (eoi || b == tml_pkg::CH_LF || b == tml_pkg::CH_CR) begin
          add_token(tml_pkg::KIND_INVALID, str_start);
          lex_fresh(b, eoi);
        end else if (b == tml_pkg::CH_BSLASH) begin
          advance(b);
          lex_mode = tml_pkg::MODE_ESC;
        end else if (b == tml_pkg::CH_QUOTE) begin
          add_token(tml_pkg::KIND_STRING, str_start);
          advance(b);
          lex_mode = tml_pkg::MODE_IDLE;
        end else begin
          advance(b);
        end
      end
      tml_pkg::MODE_ESC: begin
        if (!eoi && (b inside {tml_pkg::CH_LB, tml_pkg::CH_LT, tml_pkg::CH_LN,
                               tml_pkg::CH_LF_F, tml_pkg::CH_LR, tml_pkg::CH_QUOTE,
                               tml_pkg::CH_BSLASH, tml_pkg::CH_LE})) begin
          advance(b);
          lex_mode = tml_pkg::MODE_STR;
        end else if (!eoi && (b inside {tml_pkg::CH_LX, tml_pkg::CH_LU,
                                        tml_pkg::CH_UU})) begin
          advance(b);
          hex_left = (b == tml_pkg::CH_LX) ? tml_pkg::HEX_DIGITS_X :
                     (b == tml_pkg::CH_LU) ? tml_pkg::HEX_DIGITS_LU : tml_pkg::HEX_DIGITS_UU;
          code_point = '0;
          lex_mode = tml_pkg::MODE_HEX;
        end else begin
          add_token(tml_pkg::KIND_INVALID, str_start);
          lex_fresh(b, eoi);
        end
      end
      tml_pkg::MODE_HEX: begin
        digit = 5'h10;
        if (!eoi) begin
          if (b >= tml_pkg::CH_0 && b <= tml_pkg::CH_9)
            digit = 5'(b - tml_pkg::CH_0);
          else if (b >= tml_pkg::CH_LA && b <= tml_pkg::CH_LF_F)
            digit = 5'(b - tml_pkg::CH_LA + 8'd10);
          else if (b >= tml_pkg::CH_UA && b <= tml_pkg::CH_UF)
            digit = 5'(b - tml_pkg::CH_UA + 8'd10);
        end
        if (digit[4]) begin
          add_token(tml_pkg::KIND_INVALID, str_start);
          lex_fresh(b, eoi);
        end else begin
          code_point = {code_point[27:0], digit[3:0]};
          advance(b);
          if (hex_left != 4'd0) hex_left--;
          if (hex_left == 4'd0) begin
            if ((code_point >= tml_pkg::CP_SURR_LO && code_point <= tml_pkg::CP_SURR_HI) ||
                code_point > tml_pkg::CP_MAX) begin
              add_token(tml_pkg::KIND_INVALID, str_start);
              lex_mode = tml_pkg::MODE_IDLE;
            end else begin
              lex_mode = tml_pkg::MODE_STR;
            end
          end
        end
      end
      default: lex_fresh(b, eoi);
    endcase
    if (step_tokens.size() > 0) begin
      t = step_tokens.pop_back();
      t.last = 1'b1;
      step_tokens.push_back(t);
    end
    foreach (step_tokens[i]) due_tokens.push_back(step_tokens[i]);
    step_tokens.delete();
  endfunction

  // stimulus building
  function automatic void push_word(input logic [7:0] ch, input logic eoi = 1'b0,
                                    input bit drain = 1'b0);
    text_word_t w;
    w.ch    = ch;
    w.eoi   = eoi;
    w.drain = drain;
    text_words.push_back(w);
  endfunction

  function automatic void push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_word(s[i]);
  endfunction

  function automatic void push_hex(input logic [31:0] value, input int ndig);
    logic [3:0] nib;
    for (int i = ndig - 1; i >= 0; i--) begin
      nib = value[4*i +: 4];
      if (nib < 4'd10) push_word(tml_pkg::CH_0 + nib);
      else push_word(($urandom_range(1) ? tml_pkg::CH_LA : tml_pkg::CH_UA) + nib - 8'd10);
    end
  endfunction

  function automatic void string_body();
    logic [7:0]  ch;
    logic [31:0] cp;
    int          pick;
    repeat ($urandom_range(0, 10)) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        do ch = 8'($urandom_range(1, 255));
        while (ch inside {tml_pkg::CH_QUOTE, tml_pkg::CH_BSLASH, tml_pkg::CH_LF,
                          tml_pkg::CH_CR});
        push_word(ch);
      end else if (pick < 85) begin
        push_word(tml_pkg::CH_BSLASH);
        push_word(esc_letters[$urandom_range(7)]);
      end else begin
        push_word(tml_pkg::CH_BSLASH);
        case ($urandom_range(2))
          0: begin
            push_word(tml_pkg::CH_LX);
            push_hex($urandom_range(255), 2);
          end
          1: begin
            cp = $urandom_range(16'hFFFF);
            if (cp >= tml_pkg::CP_SURR_LO && cp <= tml_pkg::CP_SURR_HI) cp = cp ^ 32'h4000;
            push_word(tml_pkg::CH_LU);
            push_hex(cp, 4);
          end
          default: begin
            cp = $urandom_range(tml_pkg::CP_MAX);
            if (cp >= tml_pkg::CP_SURR_LO && cp <= tml_pkg::CP_SURR_HI) cp = cp ^ 32'h4000;
            push_word(tml_pkg::CH_UU);
            push_hex(cp, 8);
          end
        endcase
      end
    end
  endfunction

  function automatic void add_fragment();
    logic [7:0] ch;
    int         pick;
    int         esc;
    pick = $urandom_range(99);
    if (pick < 30) begin
      ch = punct_bytes[$urandom_range(7)];
      push_word(ch);
      if ((ch == tml_pkg::CH_LBRACK || ch == tml_pkg::CH_RBRACK) && $urandom_range(1))
        push_word(ch);
    end else if (pick < 45) begin
      repeat ($urandom_range(1, 4))
        push_word($urandom_range(1) ? tml_pkg::CH_SPACE : tml_pkg::CH_TAB);
    end else if (pick < 75) begin
      push_word(tml_pkg::CH_QUOTE);
      string_body();
      push_word(tml_pkg::CH_QUOTE);
    end else if (pick < 88) begin
      push_word(tml_pkg::CH_QUOTE);
      string_body();
      case ($urandom_range(5))
        0: begin
          push_word(tml_pkg::CH_BSLASH);
          do ch = 8'($urandom_range(1, 255));
          while (ch inside {tml_pkg::CH_LB, tml_pkg::CH_LT, tml_pkg::CH_LN,
                            tml_pkg::CH_LF_F, tml_pkg::CH_LR, tml_pkg::CH_QUOTE,
                            tml_pkg::CH_BSLASH, tml_pkg::CH_LE, tml_pkg::CH_LX,
                            tml_pkg::CH_LU, tml_pkg::CH_UU});
          push_word(ch);
        end
        1: begin
          esc = $urandom_range(2);
          push_word(tml_pkg::CH_BSLASH);
          push_word(hex_letters[esc]);
          push_hex($urandom, $urandom_range(0, (esc == 0) ? 1 : (esc == 1) ? 3 : 7));
          do ch = 8'($urandom_range(1, 255));
          while (ch inside {[tml_pkg::CH_0:tml_pkg::CH_9], [tml_pkg::CH_LA:tml_pkg::CH_LF_F],
                            [tml_pkg::CH_UA:tml_pkg::CH_UF]});
          push_word(ch);
        end
        2: begin
          push_word(tml_pkg::CH_BSLASH);
          push_word(tml_pkg::CH_LU);
          push_hex($urandom_range(tml_pkg::CP_SURR_HI, tml_pkg::CP_SURR_LO), 4);
        end
        3: begin
          push_word(tml_pkg::CH_BSLASH);
          push_word(tml_pkg::CH_UU);
          push_hex($urandom_range(32'hFFFF_FFFF, tml_pkg::CP_MAX + 1), 8);
        end
        4: push_word(tml_pkg::CH_LF);
        default: push_word(tml_pkg::CH_CR);
      endcase
    end else begin
      push_word(8'($urandom_range(1, 255)));
    end
  endfunction

  // input driver
  always @(negedge clk) begin
    text_word_t w;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (sent_cnt == taken_cnt) begin
      if (text_words.size() > 0 && !(text_words[0].drain && due_tokens.size() > 0) &&
          (quiet || $urandom_range(99) >= 7)) begin
        w = text_words.pop_front();
        data_byte    <= w.ch;
        end_of_input <= w.eoi;
        in_valid     <= 1'b1;
        sent_cnt++;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output stall, with one long hold-off
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (!hold_done && taken_cnt >= 300) begin
      hold_done = 1'b1;
      hold_left = 119;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !quiet && ($urandom_range(99) < 7);
    end
  end

  // monitor: check tokens, then predict from the accepted byte
  always @(posedge clk) begin
    token_t got;
    token_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        got = {token_kind, start_offset, token_length, line_number, column_number,
               last_of_run};
        tokens_seen++;
        kinds_seen[got.kind] = 1'b1;
        if (got.kind == tml_pkg::KIND_STRING && int'(got.len) > longest_str)
          longest_str = int'(got.len);
        if (int'(got.col) > col_peak) col_peak = int'(got.col);
        if (due_tokens.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("token %0d unexpected: kind %0d start %0d len %0d", tokens_seen,
                     got.kind, got.start, got.len);
        end else begin
          want = due_tokens.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("token %0d expected kind %0d start %0d len %0d line %0d col %0d last %0b",
                       tokens_seen, want.kind, want.start, want.len, want.line, want.col,
                       want.last);
              $display("token %0d actual   kind %0d start %0d len %0d line %0d col %0d last %0b",
                       tokens_seen, got.kind, got.start, got.len, got.line, got.col,
                       got.last);
            end
          end
        end
      end
      if (in_valid && !in_stall) begin
        lex_byte(data_byte, end_of_input);
        taken_cnt++;
      end
    end
  end

  initial begin
    int base;
    int kind_cnt;
    // directed text
    push_text("[[ ]]");
    push_word(tml_pkg::CH_TAB);
    push_text("[.]=,{}\"\\e\"");
    push_word(tml_pkg::CH_CR);
    push_word(8'hFF);
    push_text("\"\\q\"");
    push_word(tml_pkg::CH_CR);
    push_word(tml_pkg::CH_LF);
    while (text_words.size() < 780) add_fragment();
    // long plain string
    push_word(tml_pkg::CH_QUOTE, 1'b0, 1'b1);
    repeat (30) push_word(tml_pkg::CH_LA + 8'($urandom_range(25)));
    push_text("\"=\n");
    base = text_words.size();
    while (text_words.size() - base < 725) add_fragment();
    // end of text inside an open string
    push_word(tml_pkg::CH_QUOTE, 1'b0, 1'b1);
    push_text("ab");
    if ($urandom_range(1)) push_word(tml_pkg::CH_NUL);
    else push_word(8'($urandom_range(1, 255)), 1'b1);
    repeat (4) push_word(8'($urandom_range(255)), 1'($urandom_range(1)));

    repeat (10) @(negedge clk);
    rst <= 1'b0;
    while (text_words.size() > 0 || sent_cnt != taken_cnt) @(posedge clk);
    while (due_tokens.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);

    kind_cnt = 0;
    foreach (kinds_seen[i]) if (kinds_seen[i]) kind_cnt++;
    $display("lexed %0d bytes into %0d checked tokens, %0d distinct token kinds",
             taken_cnt, tokens_seen, kind_cnt);
    $display("longest string %0d bytes, column peaked at %0d, %0d mismatches",
             longest_str, col_peak, mismatches);
    if (mismatches == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    #12_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
